[design/salfu_pkg.sv]
// ---------------------------------------------------------------------------
// salfu_pkg: shared constants for the LFU cache lookup block
// Fixed port widths of the address input and of the result fields.
// ---------------------------------------------------------------------------
`default_nettype none

package salfu_pkg;

  localparam int ADDR_W    = 32;  // byte address port width
  localparam int SET_NUM_W = 6;   // set_number result width
  localparam int WAY_NUM_W = 2;   // way_number result width
  localparam int TOTAL_W   = 32;  // running counter width

endpackage

`default_nettype wire

[design/salfu_front.sv]
// ---------------------------------------------------------------------------
// salfu_front: address intake and request queue
// Masks the byte address, splits it into set and tag, and holds the split
// requests in a two-entry queue that the lookup engine drains.
// ---------------------------------------------------------------------------
`default_nettype none

module salfu_front #(
  parameter int SETS        = 64,
  parameter int BLOCK_BYTES = 16,
  parameter int ADDR_BITS   = 32,
  parameter int SET_W       = 6,
  parameter int TAG_W       = 22
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          addr_valid,
  output logic                               addr_stall,
  input  wire logic [salfu_pkg::ADDR_W-1:0]  byte_address,
  output logic                               q_valid,
  output logic [SET_W-1:0]                   q_set,
  output logic [TAG_W-1:0]                   q_tag,
  input  wire logic                          q_pop
);

  localparam int OFF_BITS = $clog2(BLOCK_BYTES);
  localparam int SET_BITS = $clog2(SETS);
  localparam logic [salfu_pkg::ADDR_W-1:0] ADDR_MASK =
    salfu_pkg::ADDR_W'((64'(1) << ADDR_BITS) - 64'(1));
  localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);

  logic [salfu_pkg::ADDR_W-1:0] addr_m;
  logic [salfu_pkg::ADDR_W-1:0] block;
  logic [SET_W-1:0]             set_in;
  logic [TAG_W-1:0]             tag_in;

  logic [SET_W-1:0] set_q [2];
  logic [TAG_W-1:0] tag_q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;

  always_comb begin
    addr_m = byte_address & ADDR_MASK;
    block  = addr_m >> OFF_BITS;
    set_in = SET_W'(block) & SET_MASK;
    tag_in = TAG_W'(block >> SET_BITS);
  end

  assign addr_stall = (fill == 2'd2);
  assign push       = addr_valid && !addr_stall;
  assign q_valid    = (fill != 2'd0);
  assign q_set      = set_q[rd_ptr];
  assign q_tag      = tag_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        fill <= fill + 2'd1;
      end else if (q_pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      set_q[wr_ptr] <= set_in;
      tag_q[wr_ptr] <= tag_in;
    end
  end

endmodule

`default_nettype wire

[design/salfu_back.sv]
// ---------------------------------------------------------------------------
// salfu_back: tag lookup and LFU replacement engine
// Reads one set's tag and count rows, resolves hit or victim, writes the
// rows back and registers the result with the running totals.
// ---------------------------------------------------------------------------
`default_nettype none

module salfu_back #(
  parameter int WAYS       = 4,
  parameter int SETS       = 64,
  parameter int COUNT_BITS = 16,
  parameter int SET_W      = 6,
  parameter int TAG_W      = 22
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_valid,
  input  wire logic [SET_W-1:0]                  q_set,
  input  wire logic [TAG_W-1:0]                  q_tag,
  output logic                                   q_pop,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic                                   hit,
  output logic [salfu_pkg::SET_NUM_W-1:0]        set_number,
  output logic [salfu_pkg::WAY_NUM_W-1:0]        way_number,
  output logic                                   evicted_valid,
  output logic [salfu_pkg::TOTAL_W-1:0]          hit_total,
  output logic [salfu_pkg::TOTAL_W-1:0]          miss_total,
  output logic [salfu_pkg::TOTAL_W-1:0]          replace_total
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;

  // Row memories: one row per set, all ways side by side.
  logic [WAYS-1:0][TAG_W-1:0]      tag_mem [SETS];
  logic [WAYS-1:0][COUNT_BITS-1:0] cnt_mem [SETS];
  logic [WAYS-1:0]                 valid_row [SETS];

  logic [WAYS-1:0][TAG_W-1:0]      tag_rd;
  logic [WAYS-1:0][COUNT_BITS-1:0] cnt_rd;
  logic [SET_W-1:0]                cur_set;
  logic [TAG_W-1:0]                cur_tag;

  logic [WAYS-1:0]                 vrow;
  logic [WAYS-1:0][COUNT_BITS-1:0] cnt_eff;
  logic [WAYS-1:0][COUNT_BITS-1:0] cnt_new;
  logic [WAYS-1:0][TAG_W-1:0]      tag_new;
  logic                            hit_any;
  logic [WAY_W-1:0]                hit_way;
  logic [WAY_W-1:0]                victim;
  logic [WAY_W-1:0]                way_sel;
  logic                            evict;
  logic                            fire;

  logic [salfu_pkg::TOTAL_W-1:0] hits_seen;
  logic [salfu_pkg::TOTAL_W-1:0] misses_seen;
  logic [salfu_pkg::TOTAL_W-1:0] repl_seen;
  logic [salfu_pkg::TOTAL_W-1:0] hits_next;
  logic [salfu_pkg::TOTAL_W-1:0] misses_next;
  logic [salfu_pkg::TOTAL_W-1:0] repl_next;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign fire  = (state == S_EXEC) && (!result_valid || !result_stall);
  assign vrow  = valid_row[cur_set];

  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    victim  = '0;
    for (int w = 0; w < WAYS; w++) begin
      cnt_eff[w] = vrow[w] ? cnt_rd[w] : '0;
    end
    // Scan downward so the lowest matching way wins.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vrow[w] && (tag_rd[w] == cur_tag)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    for (int i = 1; i < WAYS; i++) begin
      if ((cnt_eff[i] < cnt_eff[victim]) || (!vrow[i] && vrow[victim])) begin
        victim = WAY_W'(i);
      end
    end
    way_sel = hit_any ? hit_way : victim;
    evict   = !hit_any && vrow[victim];
    cnt_new = cnt_eff;
    tag_new = tag_rd;
    if (hit_any) begin
      if (cnt_eff[hit_way] != COUNT_MAX) begin
        cnt_new[hit_way] = cnt_eff[hit_way] + COUNT_BITS'(1);
      end
    end else begin
      cnt_new[victim] = COUNT_BITS'(1);
      tag_new[victim] = cur_tag;
    end
    hits_next   = hits_seen + salfu_pkg::TOTAL_W'(hit_any);
    misses_next = misses_seen + salfu_pkg::TOTAL_W'(!hit_any);
    repl_next   = repl_seen + salfu_pkg::TOTAL_W'(evict);
  end

  // Row read on pop, row write back when the item completes.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      tag_rd  <= tag_mem[q_set];
      cnt_rd  <= cnt_mem[q_set];
      cur_set <= q_set;
      cur_tag <= q_tag;
    end
    if (fire) begin
      tag_mem[cur_set] <= tag_new;
      cnt_mem[cur_set] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SETS; s++) begin
        valid_row[s] <= '0;
      end
    end else if (fire && !hit_any) begin
      valid_row[cur_set][victim] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      hits_seen    <= '0;
      misses_seen  <= '0;
      repl_seen    <= '0;
    end else begin
      if (fire) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state         <= S_IDLE;
            hits_seen     <= hits_next;
            misses_seen   <= misses_next;
            repl_seen     <= repl_next;
            hit           <= hit_any;
            set_number    <= salfu_pkg::SET_NUM_W'(cur_set);
            way_number    <= salfu_pkg::WAY_NUM_W'(way_sel);
            evicted_valid <= evict;
            hit_total     <= hits_next;
            miss_total    <= misses_next;
            replace_total <= repl_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/set_assoc_cache_lfu_lookup.sv]
// ---------------------------------------------------------------------------
// set_assoc_cache_lfu_lookup: tag and LFU replacement side of a cache
// Each transfer on the address channel is one access. It returns exactly one
// result: hit or miss, the set, the way that hit or was filled, whether a
// valid line was evicted, and the running hit, miss and replacement totals.
// The lookup engine reads the set's tag and use-count rows, then compares,
// picks the least-used victim and writes the rows back, waiting while a held
// result is stalled; only then does it take the next queued access. A
// two-entry queue lets addresses arrive while the engine works, and a result
// register holds a finished result while the next access is looked up.
// All valid bits are cleared at reset; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lfu_lookup #(
  parameter int WAYS        = 4,
  parameter int SETS        = 64,
  parameter int BLOCK_BYTES = 16,
  parameter int COUNT_BITS  = 16,
  parameter int ADDR_BITS   = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              addr_valid,
  output logic                                   addr_stall,
  input  wire logic [salfu_pkg::ADDR_W-1:0]      byte_address,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic                                   hit,
  output logic [salfu_pkg::SET_NUM_W-1:0]        set_number,
  output logic [salfu_pkg::WAY_NUM_W-1:0]        way_number,
  output logic                                   evicted_valid,
  output logic [salfu_pkg::TOTAL_W-1:0]          hit_total,
  output logic [salfu_pkg::TOTAL_W-1:0]          miss_total,
  output logic [salfu_pkg::TOTAL_W-1:0]          replace_total
);

  localparam int OFF_BITS = $clog2(BLOCK_BYTES);
  localparam int SET_BITS = $clog2(SETS);
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_W    = ADDR_BITS - OFF_BITS - SET_BITS;

  logic             q_valid;
  logic [SET_W-1:0] q_set;
  logic [TAG_W-1:0] q_tag;
  logic             q_pop;

  salfu_front #(
    .SETS        (SETS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .ADDR_BITS   (ADDR_BITS),
    .SET_W       (SET_W),
    .TAG_W       (TAG_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .addr_valid   (addr_valid),
    .addr_stall   (addr_stall),
    .byte_address (byte_address),
    .q_valid      (q_valid),
    .q_set        (q_set),
    .q_tag        (q_tag),
    .q_pop        (q_pop)
  );

  salfu_back #(
    .WAYS       (WAYS),
    .SETS       (SETS),
    .COUNT_BITS (COUNT_BITS),
    .SET_W      (SET_W),
    .TAG_W      (TAG_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_set         (q_set),
    .q_tag         (q_tag),
    .q_pop         (q_pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .hit           (hit),
    .set_number    (set_number),
    .way_number    (way_number),
    .evicted_valid (evicted_valid),
    .hit_total     (hit_total),
    .miss_total    (miss_total),
    .replace_total (replace_total)
  );

endmodule

`default_nettype wire
